// ----- rtl/core/clipped_overlay_alpha_blend_core_macros.svh -----
// assertion macros for the overlay blend core checker
// no dependencies; included by the checker file
`ifndef CLIPPED_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH
`define CLIPPED_OVERLAY_ALPHA_BLEND_CORE_MACROS_SVH

// overlapping implication, checked outside reset
`define COB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("overlay blend check failed");

// next-cycle implication, checked outside reset
`define COB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("overlay blend check failed");

// plain check that also holds during reset
`define COB_ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) \
    else $error("overlay blend check failed");

`endif

// ----- rtl/core/cob_pkg.sv -----
// shared types and constants of the overlay blend core
// no dependencies; used by the top level, cob_addr, cob_lane and the checker
package cob_pkg;

  localparam int CoordW  = 12;
  localparam int CfgW    = 13;
  localparam int CfgIdxW = 2;
  localparam int ChanW   = 8;
  localparam int TexelW  = 32;
  localparam int IdxW    = 12;
  localparam int NumChan = 3;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  localparam logic [CfgW-1:0] ResetWidth  = 13'd64;
  localparam logic [CfgW-1:0] ResetHeight = 13'd64;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindPixel = 1'b1
  } cob_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegOverlayX      = 2'd0,
    RegOverlayY      = 2'd1,
    RegOverlayWidth  = 2'd2,
    RegOverlayHeight = 2'd3
  } cob_reg_e;

  typedef struct packed {
    logic p1;
    logic p2;
    logic p3;
    logic p4;
  } cob_addr_en_t;

  typedef struct packed {
    logic mul;
    logic sum;
  } cob_lane_en_t;

endpackage

// ----- rtl/core/clipped_overlay_alpha_blend_core.sv -----
// top level of the overlay blend core: handshake, config, store and lane merge
// depends on cob_pkg, cob_addr, cob_lane and cob_ram
//
// Takes one item per clock while the output is not held. Stages 1-4 test
// the window and form the texel address modulo the store depth, stage 5
// reads or writes the overlay store, stages 6-7 run three channel lanes in
// parallel and the last stage doubles as the output register. Loads travel
// the same pipeline and write the store at stage 5, so loads and reads keep
// their order; loads give no result. A held output only stalls the stages
// that are full, so bubbles close up and input keeps flowing while the
// result waits. Texels must be loaded before a pixel that reads them arrives.
// Registers must be written only while the pipeline is empty; the block
// itself does not enforce this.
module clipped_overlay_alpha_blend_core #(
  parameter int OVERLAY_TEXELS = 4096,
  parameter int COORD_BITS     = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [cob_pkg::IdxW-1:0]      texel_index_i,
  input  logic [cob_pkg::TexelW-1:0]    texel_word_i,
  input  logic [cob_pkg::CoordW-1:0]    pixel_col_i,
  input  logic [cob_pkg::CoordW-1:0]    pixel_row_i,
  input  logic [cob_pkg::ChanW-1:0]     in_ch0_i,
  input  logic [cob_pkg::ChanW-1:0]     in_ch1_i,
  input  logic [cob_pkg::ChanW-1:0]     in_ch2_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cob_pkg::ChanW-1:0]     out_ch0_o,
  output logic [cob_pkg::ChanW-1:0]     out_ch1_o,
  output logic [cob_pkg::ChanW-1:0]     out_ch2_o,
  output logic                          covered_o,
  input  logic                          cfg_we_i,
  input  logic [cob_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cob_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam int NS = 7;
  localparam int RamStage = 5;
  localparam int AW = (OVERLAY_TEXELS > 1) ? $clog2(OVERLAY_TEXELS) : 1;
  localparam int CH = cob_pkg::ChanW;
  localparam int NC = cob_pkg::NumChan;

  logic signed [cob_pkg::CfgW-1:0] ox_q, oy_q;
  logic [cob_pkg::CfgW-1:0]        ow_q, oh_q;

  logic [NS:1]   vld_q, vld_d;
  logic [NS+1:1] rdy;

  logic                       kind_q  [1:RamStage-1];
  logic [cob_pkg::IdxW-1:0]   idx_q   [1:RamStage-1];
  logic [cob_pkg::TexelW-1:0] word_q  [1:RamStage-1];
  logic [NC-1:0][CH-1:0]      dst_q   [1:NS];
  logic [NC-1:0][CH-1:0]      dst_in;
  logic                       hit_q   [RamStage:NS];

  logic                       hit4;
  logic [AW-1:0]              addr4;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_addr;
  logic [cob_pkg::TexelW-1:0] ram_rdata;
  logic                       idx_in_range;
  logic                       is_pixel4;

  cob_pkg::cob_addr_en_t addr_en;
  cob_pkg::cob_lane_en_t lane_en;
  logic [NC-1:0][CH-1:0] lane_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0;
      oy_q <= '0;
      ow_q <= cob_pkg::ResetWidth;
      oh_q <= cob_pkg::ResetHeight;
    end else if (cfg_we_i) begin
      case (cob_pkg::cob_reg_e'(cfg_idx_i))
        cob_pkg::RegOverlayX:      ox_q <= $signed(cfg_wdata_i);
        cob_pkg::RegOverlayY:      oy_q <= $signed(cfg_wdata_i);
        cob_pkg::RegOverlayWidth:  ow_q <= cfg_wdata_i;
        cob_pkg::RegOverlayHeight: oh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when empty or when its content moves on
  assign is_pixel4 = (kind_q[RamStage-1] == cob_pkg::KindPixel);

  always_comb begin
    rdy[NS+1] = out_ready_i;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[1] = in_valid_i;
    for (int k = 2; k <= NS; k++) begin
      vld_d[k] = vld_q[k-1];
    end
    vld_d[RamStage] = vld_q[RamStage-1] && is_pixel4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign in_ready_o = rdy[1];

  // sideband shift line
  assign dst_in = {in_ch2_i, in_ch1_i, in_ch0_i};

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      kind_q[1] <= kind_i;
      idx_q[1]  <= texel_index_i;
      word_q[1] <= texel_word_i;
      dst_q[1]  <= dst_in;
    end
    for (int k = 2; k < RamStage; k++) begin
      if (rdy[k]) begin
        kind_q[k] <= kind_q[k-1];
        idx_q[k]  <= idx_q[k-1];
        word_q[k] <= word_q[k-1];
      end
    end
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) begin
        dst_q[k] <= dst_q[k-1];
      end
    end
    if (rdy[RamStage]) begin
      hit_q[RamStage] <= hit4;
    end
    for (int k = RamStage + 1; k <= NS; k++) begin
      if (rdy[k]) begin
        hit_q[k] <= hit_q[k-1];
      end
    end
  end

  // window and address
  assign addr_en = '{p1: rdy[1], p2: rdy[2], p3: rdy[3], p4: rdy[4]};

  cob_addr #(
    .OVERLAY_TEXELS (OVERLAY_TEXELS),
    .COORD_BITS     (COORD_BITS)
  ) u_addr (
    .clk_i       (clk_i),
    .en_i        (addr_en),
    .pixel_col_i (pixel_col_i),
    .pixel_row_i (pixel_row_i),
    .ox_i        (ox_q),
    .oy_i        (oy_q),
    .ow_i        (ow_q),
    .oh_i        (oh_q),
    .hit_o       (hit4),
    .addr_o      (addr4)
  );

  // overlay store access
  assign idx_in_range = (32'(idx_q[RamStage-1]) < 32'(OVERLAY_TEXELS));
  assign ram_we   = rdy[RamStage] && vld_q[RamStage-1] && !is_pixel4 && idx_in_range;
  assign ram_re   = rdy[RamStage];
  assign ram_addr = is_pixel4 ? addr4 : AW'(idx_q[RamStage-1]);

  cob_ram #(
    .Width (cob_pkg::TexelW),
    .Depth (OVERLAY_TEXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (word_q[RamStage-1]),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // channel lanes
  assign lane_en = '{mul: rdy[RamStage+1], sum: rdy[RamStage+2]};

  for (genvar i = 0; i < NC; i++) begin : g_lane
    cob_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .alpha_i (ram_rdata[cob_pkg::TexelW-1 -: CH]),
      .src_i   (ram_rdata[CH*(NC-1-i) +: CH]),
      .dst_i   (dst_q[RamStage][i]),
      .res_o   (lane_res[i])
    );
  end

  // merge lanes with pass-through
  assign out_valid_o = vld_q[NS];
  assign covered_o   = hit_q[NS];
  assign out_ch0_o   = hit_q[NS] ? lane_res[0] : dst_q[NS][0];
  assign out_ch1_o   = hit_q[NS] ? lane_res[1] : dst_q[NS][1];
  assign out_ch2_o   = hit_q[NS] ? lane_res[2] : dst_q[NS][2];

endmodule

// ----- rtl/core/cob_ram.sv -----
// generic single-clock ram, one write and one registered read per cycle
// no dependencies
module cob_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cob_addr.sv -----
// window test and texel address pipeline (four stages)
// depends on cob_pkg; address wraps modulo the store depth by reciprocal
module cob_addr #(
  parameter int OVERLAY_TEXELS = 4096,
  parameter int COORD_BITS     = 12
) (
  input  logic                                                       clk_i,
  input  cob_pkg::cob_addr_en_t                                      en_i,
  input  logic [cob_pkg::CoordW-1:0]                                 pixel_col_i,
  input  logic [cob_pkg::CoordW-1:0]                                 pixel_row_i,
  input  logic signed [cob_pkg::CfgW-1:0]                            ox_i,
  input  logic signed [cob_pkg::CfgW-1:0]                            oy_i,
  input  logic [cob_pkg::CfgW-1:0]                                   ow_i,
  input  logic [cob_pkg::CfgW-1:0]                                   oh_i,
  output logic                                                       hit_o,
  output logic [(OVERLAY_TEXELS > 1 ? $clog2(OVERLAY_TEXELS) : 1)-1:0] addr_o
);

  localparam int CW       = cob_pkg::CoordW;
  localparam int OW       = cob_pkg::CfgW;
  localparam int DW       = OW + 2;
  localparam int LW       = 2 * OW;
  localparam int AW       = (OVERLAY_TEXELS > 1) ? $clog2(OVERLAY_TEXELS) : 1;
  localparam int Log2N    = $clog2(OVERLAY_TEXELS);
  localparam int Shift    = LW + Log2N;
  localparam int RW       = LW + 2;
  localparam int PW       = LW + RW;
  localparam int UsedBits = (COORD_BITS < CW) ? COORD_BITS : CW;
  localparam longint unsigned Recip =
    ((64'd1 << Shift) + 64'(OVERLAY_TEXELS) - 64'd1) / 64'(OVERLAY_TEXELS);
  localparam logic [CW-1:0] CoordMask = CW'((64'd1 << UsedBits) - 64'd1);

  logic [CW-1:0]        col_m, row_m;
  logic signed [DW-1:0] dx_d, dy_d;
  logic                 hit1_d;
  logic                 hit1_q, hit2_q, hit3_q, hit4_q;
  logic [OW-1:0]        dx1_q, dy1_q;
  logic [LW-1:0]        lin2_d, lin2_q, lin3_q;
  logic [PW-1:0]        prod3_d, prod3_q;
  logic [LW-1:0]        quo, rem;
  logic [AW-1:0]        addr4_q;

  // stage 1: offsets into the window and the window test
  always_comb begin
    col_m  = pixel_col_i & CoordMask;
    row_m  = pixel_row_i & CoordMask;
    dx_d   = DW'($signed({1'b0, col_m})) - DW'(ox_i);
    dy_d   = DW'($signed({1'b0, row_m})) - DW'(oy_i);
    hit1_d = !dx_d[DW-1] && !dy_d[DW-1] &&
             (dx_d[DW-2:0] < (DW-1)'(ow_i)) && (dy_d[DW-2:0] < (DW-1)'(oh_i));
  end

  // stage 2: row-major linear address
  assign lin2_d = LW'(dy1_q) * LW'(ow_i) + LW'(dx1_q);

  // stage 3: quotient estimate by reciprocal
  assign prod3_d = PW'(lin2_q) * PW'(Recip);

  // stage 4: remainder
  always_comb begin
    quo = LW'(prod3_q >> Shift);
    rem = lin3_q - LW'(quo * LW'(OVERLAY_TEXELS));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.p1) begin
      hit1_q <= hit1_d;
      dx1_q  <= dx_d[OW-1:0];
      dy1_q  <= dy_d[OW-1:0];
    end
    if (en_i.p2) begin
      hit2_q <= hit1_q;
      lin2_q <= lin2_d;
    end
    if (en_i.p3) begin
      hit3_q  <= hit2_q;
      lin3_q  <= lin2_q;
      prod3_q <= prod3_d;
    end
    if (en_i.p4) begin
      hit4_q  <= hit3_q;
      addr4_q <= AW'(rem);
    end
  end

  assign hit_o  = hit4_q;
  assign addr_o = addr4_q;

endmodule

// ----- rtl/core/cob_lane.sv -----
// one channel blend lane: a*src/255 + (255-a)*dst/255, two stages
// depends on cob_pkg
module cob_lane (
  input  logic                        clk_i,
  input  cob_pkg::cob_lane_en_t       en_i,
  input  logic [cob_pkg::ChanW-1:0]   alpha_i,
  input  logic [cob_pkg::ChanW-1:0]   src_i,
  input  logic [cob_pkg::ChanW-1:0]   dst_i,
  output logic [cob_pkg::ChanW-1:0]   res_o
);

  localparam int CH = cob_pkg::ChanW;
  localparam int MW = 2 * CH;

  logic [CH-1:0]   inv_alpha;
  logic [MW-1:0]   fg_d, bg_d, fg_q, bg_q;
  logic [MW:0]     fg_t, bg_t;
  logic [CH-1:0]   fg_div, bg_div;
  logic [CH-1:0]   res_q;

  assign inv_alpha = cob_pkg::ChanMax - alpha_i;
  assign fg_d      = MW'(alpha_i) * MW'(src_i);
  assign bg_d      = MW'(inv_alpha) * MW'(dst_i);

  // exact floor(x/255) for 16-bit products
  always_comb begin
    fg_t   = (MW+1)'(fg_q) + (MW+1)'(fg_q >> CH) + (MW+1)'(1);
    bg_t   = (MW+1)'(bg_q) + (MW+1)'(bg_q >> CH) + (MW+1)'(1);
    fg_div = CH'(fg_t >> CH);
    bg_div = CH'(bg_t >> CH);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      fg_q <= fg_d;
      bg_q <= bg_d;
    end
    if (en_i.sum) begin
      res_q <= fg_div + bg_div;
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/cob_checker.sv -----
// port-level checker for the overlay blend core, bound to the top level
// depends on cob_pkg and the assertion macro header
`include "clipped_overlay_alpha_blend_core_macros.svh"

module cob_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [cob_pkg::ChanW-1:0]   out_ch0_o,
  input logic [cob_pkg::ChanW-1:0]   out_ch1_o,
  input logic [cob_pkg::ChanW-1:0]   out_ch2_o,
  input logic                        covered_o
);

  logic [cob_pkg::NumChan*cob_pkg::ChanW:0] out_payload;

  assign out_payload = {out_ch0_o, out_ch1_o, out_ch2_o, covered_o};

  // a held result stays offered
  `COB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // a held result keeps its payload
  `COB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_payload))

  // an empty output register never blocks the input
  `COB_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // no result is offered in reset
  `COB_ASSERT_ALWAYS(a_reset_quiet, clk_i, rst_ni || !out_valid_o)

endmodule

bind clipped_overlay_alpha_blend_core cob_checker u_cob_checker (.*);
